[sv/spq_pkg.sv]
`default_nettype none
package spq_pkg;

  localparam int ValueW = 32;
  localparam int PrioW  = 8;
  localparam int StatusW = 2;
  localparam int CountW = 5;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [PrioW-1:0]         prio;
  } entry_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [ValueW-1:0] value;
    logic [PrioW-1:0]         prio;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [ValueW-1:0] out_value;
    logic [PrioW-1:0]         out_prio;
    logic [CountW-1:0]        count;
  } res_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[sv/sorted_priority_queue_core.sv]
`default_nettype none
// Sorted priority queue built as a row of entry cells.
// Latency: the result strobes in the cycle after the request is accepted.
// Throughput: one request per cycle; every cell compares and shifts in the same cycle.
// busy stays low, the result is shown for one cycle and the receiver cannot stall.
// Reset clears the entry count and the result strobe; cell contents are not cleared.
module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire spq_pkg::req_t request,
  output spq_pkg::res_t      result,
  output logic               strobe
);

  localparam int HeldW = $clog2(DEPTH + 1);
  localparam logic [HeldW-1:0] FullCount = HeldW'(DEPTH);

  logic [HeldW-1:0]   held;
  logic [HeldW-1:0]   held_next;
  spq_pkg::res_t      result_next;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t    new_entry;
  spq_pkg::entry_t    cell_entry [DEPTH];
  logic [DEPTH-1:0]   cell_keep;
  logic               accept;
  logic               is_full;
  logic               is_empty;

  // Every request is handled as it arrives, so never hold off the requester.
  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (held == FullCount);
  assign is_empty = (held == '0);

  assign new_entry.value = request.value;
  assign new_entry.prio  = request.prio;

  // Insert only when room remains; remove only when something is held.
  assign ctrl.insert = accept && (request.kind == spq_pkg::OP_ENQ) && !is_full;
  assign ctrl.remove = accept && (request.kind == spq_pkg::OP_DEQ) && !is_empty;

  // Cell chain: position 0 is the head. On insert each cell either keeps its
  // entry, takes the new entry (first non-keeping cell) or takes its left
  // neighbor's entry. On remove every cell takes its right neighbor's entry; the tail keeps its own.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            occ;
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_k;

    assign occ = (HeldW'(i) < held);

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_k = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ),
      .new_entry  (new_entry),
      .left_entry (left_e),
      .left_keep  (left_k),
      .right_entry(right_e),
      .entry      (cell_entry[i]),
      .keep       (cell_keep[i])
    );
  end

  always_comb begin
    held_next = held;
    if (ctrl.insert) begin
      held_next = held + HeldW'(1);
    end else if (ctrl.remove) begin
      held_next = held - HeldW'(1);
    end
  end

  // Build the result: head entry on dequeue of a non-empty queue, zeros otherwise.
  always_comb begin
    result_next.status    = spq_pkg::ST_DONE;
    result_next.out_value = '0;
    result_next.out_prio  = '0;
    if (request.kind == spq_pkg::OP_ENQ) begin
      if (is_full) begin
        result_next.status = spq_pkg::ST_FULL;
      end
    end else if (is_empty) begin
      result_next.status = spq_pkg::ST_EMPTY;
    end else begin
      result_next.out_value = cell_entry[0].value;
      result_next.out_prio  = cell_entry[0].prio;
    end
    result_next.count = spq_pkg::CountW'(held_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= '0;
      strobe <= 1'b0;
    end else begin
      held   <= held_next;
      strobe <= accept;
    end
  end

  // Result payload carries no reset; strobe qualifies it.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> strobe)
    else $error("result strobe missing after accepted request");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= FullCount)
    else $error("entry count above depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status == spq_pkg::ST_EMPTY) |-> (result.count == '0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status == spq_pkg::ST_FULL) |-> (held == FullCount))
    else $error("full status while space remained");

endmodule
`default_nettype wire

[sv/spq_cell.sv]
`default_nettype none
module spq_cell (
  input  wire logic                clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic                occupied,
  input  wire spq_pkg::entry_t     new_entry,
  input  wire spq_pkg::entry_t     left_entry,
  input  wire logic                left_keep,
  input  wire spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t          entry,
  output logic                     keep
);

  spq_pkg::entry_t entry_next;

  // Keep position when the held entry sorts at or ahead of the new one.
  assign keep = occupied && (entry.prio <= new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (keep) begin
        entry_next = entry;
      end else if (left_keep) begin
        entry_next = new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire
